[src/halo_shape_mass_histogram_defines.svh]
// Assertion macros for the halo shape/mass histogram checker.
// Used by hsmh_checker.sv only; no other dependencies.
`ifndef HALO_SHAPE_MASS_HISTOGRAM_DEFINES_SVH
`define HALO_SHAPE_MASS_HISTOGRAM_DEFINES_SVH

// clocked check, off while reset is asserted
`define HSMH_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define HSMH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/hsmh_pkg.sv]
// Shared types and constants for the halo shape/mass histogram.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package hsmh_pkg;

  localparam int X_BINS = 128;
  localparam int Y_BINS = 128;

  localparam int MASS_W   = 50;
  localparam int RATIO_W  = 17;
  localparam int HUBBLE_W = 17;
  localparam int BIN_W    = 7;
  localparam int COUNT_W  = 32;
  localparam int TOTAL_W  = 40;
  localparam int LOG_W    = 21;   // log10 in Q.16, below 16 << 16
  localparam int ROOT_W   = 17;

  localparam int ADDR_W   = $clog2(X_BINS * Y_BINS);
  localparam int XQ_W     = $clog2(X_BINS) + 1;        // x quotient never exceeds X_BINS
  localparam int XCNT_W   = $clog2(XQ_W);
  localparam int DIV_W    = LOG_W + XQ_W + 1;
  localparam int CPROD_W  = LOG_W + 1 + 31;
  localparam int NUM_W    = 48;
  localparam int YQ_W     = 17;

  localparam logic [MASS_W-1:0] MASS_FLOOR = 50'd141200000000;
  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;
  localparam logic [29:0] K007_Q32    = 30'd300647711;
  localparam int K068_Q16   = 44564;
  localparam int LOG_TWELVE = 12 * 65536;
  localparam int Y_HALF     = Y_BINS / 2;
  localparam int Y_NUM_K    = Y_HALF * 10;
  localparam int Y_OFS      = Y_HALF * 3 * 65536;
  localparam int Y_RECIP    = ((1 << 17) + 2) / 3;       // floor(x/3) for x below 2^17

  typedef enum logic [1:0] {
    CFG_MIN_MASS = 2'd0,
    CFG_MAX_MASS = 2'd1,
    CFG_HUBBLE   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    logic                op;
    logic [MASS_W-1:0]   halo_mass;
    logic [RATIO_W-1:0]  ratio_q;
    logic [RATIO_W-1:0]  ratio_s;
    logic [BIN_W-1:0]    read_x;
    logic [BIN_W-1:0]    read_y;
  } in_word_t;

  typedef struct packed {
    logic                accepted;
    logic [BIN_W-1:0]    bin_x;
    logic [BIN_W-1:0]    bin_y;
    logic [COUNT_W-1:0]  bin_count;
    logic [TOTAL_W-1:0]  total_count;
  } out_word_t;

  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_data;
  } mem_req_t;

endpackage

[src/hsmh_log10.sv]
// Iterative log10 unit, Q.16 result: normalize, 16 squarings, scale.
// Depends on hsmh_pkg.
`timescale 1ns / 1ps
module hsmh_log10 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hsmh_pkg::MASS_W-1:0] x_i,
  output logic                       done_o,
  output logic [hsmh_pkg::LOG_W-1:0] log_o
);
  import hsmh_pkg::*;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_NORM = 5'b00010,
    L_SQR  = 5'b00100,
    L_MUL  = 5'b01000,
    L_DONE = 5'b10000
  } lstate_e;

  lstate_e            state_q, state_d;
  logic [MASS_W-1:0]  xn_q, xn_d;
  logic [5:0]         z_q, z_d;
  logic [30:0]        y_q, y_d;
  logic [15:0]        frac_q, frac_d;
  logic [3:0]         step_q, step_d;
  logic               zero_q, zero_d;
  logic [LOG_W-1:0]   log_q, log_d;

  logic [5:0]   amt, shr, e;
  logic         top_zero;
  logic [MASS_W-1:0] xn_next;
  logic [61:0]  sq;
  logic [31:0]  ysq;
  logic [52:0]  prod;

  always_comb begin
    amt      = 6'd32 >> step_q[2:0];
    shr      = 6'(MASS_W) - amt;
    top_zero = (xn_q >> shr) == '0;
    xn_next  = top_zero ? (xn_q << amt) : xn_q;
    sq       = 62'(y_q) * 62'(y_q);
    ysq      = sq[61:30];
    e        = 6'(MASS_W - 1) - z_q;
    prod     = 53'({e, frac_q}) * 53'(LOG10_2_Q32);
  end

  always_comb begin
    state_d = state_q;
    xn_d    = xn_q;
    z_d     = z_q;
    y_d     = y_q;
    frac_d  = frac_q;
    step_d  = step_q;
    zero_d  = zero_q;
    log_d   = log_q;
    unique case (state_q)
      L_IDLE, L_DONE: begin
        if (start_i) begin
          xn_d    = x_i;
          zero_d  = (x_i == '0);
          z_d     = '0;
          step_d  = '0;
          frac_d  = '0;
          state_d = L_NORM;
        end else begin
          state_d = L_IDLE;
        end
      end
      L_NORM: begin
        xn_d   = xn_next;
        z_d    = top_zero ? z_q + amt : z_q;
        step_d = step_q + 4'd1;
        if (step_q == 4'd5) begin
          y_d     = xn_next[MASS_W-1:MASS_W-31];
          step_d  = '0;
          state_d = L_SQR;
        end
      end
      L_SQR: begin
        y_d    = ysq[31] ? ysq[31:1] : ysq[30:0];
        frac_d = {frac_q[14:0], ysq[31]};
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) state_d = L_MUL;
      end
      L_MUL: begin
        log_d   = zero_q ? '0 : prod[52:32];
        state_d = L_DONE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xn_q   <= xn_d;
    z_q    <= z_d;
    y_q    <= y_d;
    frac_q <= frac_d;
    step_q <= step_d;
    zero_q <= zero_d;
    log_q  <= log_d;
  end

  assign done_o = (state_q == L_DONE);
  assign log_o  = log_q;

endmodule

[src/hsmh_isqrt.sv]
// Bit-serial integer square root of the q*s product, one result bit per cycle.
// Depends on hsmh_pkg.
`timescale 1ns / 1ps
module hsmh_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hsmh_pkg::RATIO_W-1:0] q_i,
  input  logic [hsmh_pkg::RATIO_W-1:0] s_i,
  output logic                         done_o,
  output logic [hsmh_pkg::ROOT_W-1:0]  root_o
);
  import hsmh_pkg::*;

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_RUN  = 3'b010,
    R_DONE = 3'b100
  } rstate_e;

  rstate_e     state_q, state_d;
  logic [33:0] rem_q, rem_d;
  logic [34:0] r_q, r_d;
  logic [4:0]  k_q, k_d;

  logic [34:0] bitv, tmp;
  logic        ge;

  always_comb begin
    bitv = 35'(1) << {k_q, 1'b0};
    tmp  = r_q + bitv;
    ge   = {1'b0, rem_q} >= tmp;
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    r_d     = r_q;
    k_d     = k_q;
    unique case (state_q)
      R_IDLE, R_DONE: begin
        if (start_i) begin
          rem_d   = 34'(q_i) * 34'(s_i);
          r_d     = '0;
          k_d     = 5'd16;
          state_d = R_RUN;
        end
      end
      R_RUN: begin
        if (ge) begin
          rem_d = 34'({1'b0, rem_q} - tmp);
          r_d   = (r_q >> 1) + bitv;
        end else begin
          r_d   = r_q >> 1;
        end
        k_d = k_q - 5'd1;
        if (k_q == '0) state_d = R_DONE;
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    r_q   <= r_d;
    k_q   <= k_d;
  end

  assign done_o = (state_q == R_DONE);
  assign root_o = r_q[ROOT_W-1:0];

endmodule

[src/hsmh_hist_mem.sv]
// Histogram count memory: one read and one write port, registered read data,
// and a clearing pass after reset. Depends on hsmh_pkg.
`timescale 1ns / 1ps
module hsmh_hist_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hsmh_pkg::mem_req_t            req_i,
  output logic [hsmh_pkg::COUNT_W-1:0]  rd_data_o,
  output logic                          clr_done_o
);
  import hsmh_pkg::*;

  localparam int DEPTH = X_BINS * Y_BINS;

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] rd_q;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic               done_q, done_d;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [COUNT_W-1:0] wdata;

  always_comb begin
    clr_d  = clr_q;
    done_d = done_q;
    if (!done_q) begin
      clr_d = clr_q + 1'b1;
      if (32'(clr_q) == DEPTH - 1) done_d = 1'b1;
    end
    we    = done_q ? req_i.wr_en   : 1'b1;
    waddr = done_q ? req_i.wr_addr : clr_q;
    wdata = done_q ? req_i.wr_data : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      clr_q  <= clr_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (req_i.rd_en) rd_q <= mem[req_i.rd_addr];
  end

  assign rd_data_o  = rd_q;
  assign clr_done_o = done_q;

endmodule

[src/halo_shape_mass_histogram.sv]
// Two-dimensional histogram of halo mass against axis-ratio shape.
// Top level: sequencer, bin arithmetic, log/sqrt units and count memory.
// Depends on hsmh_pkg, hsmh_log10, hsmh_isqrt, hsmh_hist_mem.
//
// Usage:
//  - in channel (in_valid_i/in_ready_o/in_word_i): one word per add or read.
//  - out channel (out_valid_o/out_ready_i/out_word_o): exactly one result
//    word per input word, in order.
//  - cfg port: cfg_we_i with cfg_idx_i (0 min_mass, 1 max_mass,
//    2 hubble_scale) and cfg_data_i; written at once. The user must
//    write only while the block is idle; the block does not enforce it.
//  - One word at a time. An add runs the log10 unit three times (sample,
//    min, max bound), then the x-bin divider (8 steps) and the memory
//    update. An add dropped at the mass range check goes to S_OUT. The next
//    word is taken in the cycle after a result enters the output register.
//  - After reset the count memory is swept to zero, one entry per cycle,
//    over all 16384 entries; in_ready_o stays low until the sweep ends. Config
//    writes are taken during the sweep.
//  - A finished word sits in the output register; the next input word is
//    accepted while it waits, but its result is held until the output frees.
`timescale 1ns / 1ps
module halo_shape_mass_histogram (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  hsmh_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output hsmh_pkg::out_word_t            out_word_o,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [hsmh_pkg::MASS_W-1:0]    cfg_data_i
);
  import hsmh_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_RDATA = 15'b000000000000010,
    S_MUL   = 15'b000000000000100,
    S_MSUM  = 15'b000000000001000,
    S_CHK   = 15'b000000000010000,
    S_LM    = 15'b000000000100000,
    S_LMIN  = 15'b000000001000000,
    S_LMAX  = 15'b000000010000000,
    S_CALC  = 15'b000000100000000,
    S_YNUM  = 15'b000001000000000,
    S_YDIV  = 15'b000010000000000,
    S_XDIV  = 15'b000100000000000,
    S_FIN   = 15'b001000000000000,
    S_MRD   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  // control
  state_e             state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [MASS_W-1:0]  min_q, max_q;
  logic [HUBBLE_W-1:0] hub_q;

  // datapath
  in_word_t           in_q, in_d;
  out_word_t          res_q, res_d, out_q, out_d;
  logic [50:0]        phi_q, phi_d;
  logic [32:0]        plo_q, plo_d;
  logic [50:0]        m_q, m_d;
  logic [LOG_W-1:0]   lm_q, lm_d, lmin_q, lmin_d, lmax_q, lmax_d;
  logic signed [LOG_W:0] den_q, den_d;
  logic [DIV_W-1:0]   xrem_q, xrem_d, dsh_q, dsh_d;
  logic [XQ_W-1:0]    ix_q, ix_d;
  logic [XCNT_W-1:0]  xcnt_q, xcnt_d;
  logic signed [CPROD_W-1:0] cprod_q, cprod_d;
  logic signed [NUM_W-1:0]   num_q, num_d;
  logic               yneg_q, yneg_d;
  logic [YQ_W-1:0]    qy_q, qy_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;

  // unit hookups
  logic               log_start, log_done;
  logic [MASS_W-1:0]  log_x;
  logic [LOG_W-1:0]   log_res;
  logic               sq_start, sq_done;
  logic [ROOT_W-1:0]  root;
  mem_req_t           mreq;
  logic [COUNT_W-1:0] mrd;
  logic               clr_done;

  // comb helpers
  logic               in_acc, out_free, mass_ok, rd_in_range, bin_ok;
  logic signed [LOG_W:0]     den_c;
  logic signed [LOG_W+1:0]   ldiff;
  logic signed [21:0]        center;
  logic signed [NUM_W-1:0]   d_ext, kmul, kofs;
  logic [NUM_W-1:0]          mag;
  logic [YQ_W-1:0]           x17;
  logic [33:0]               rprod;
  logic               xge;
  logic [COUNT_W-1:0] newc;
  logic [TOTAL_W-1:0] total_inc;
  out_word_t          drop_word;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    mass_ok = (m_q >= {1'b0, min_q}) && (m_q < {1'b0, max_q}) &&
              (m_q >= {1'b0, MASS_FLOOR});
    rd_in_range = (32'(in_word_i.read_x) < X_BINS) && (32'(in_word_i.read_y) < Y_BINS);
    den_c  = $signed({1'b0, lmax_q}) - $signed({1'b0, lmin_q});
    ldiff  = $signed({2'b00, lm_q}) - $signed((LOG_W+2)'(LOG_TWELVE));
    // center = 0.68 - 0.07*(log10 m - 12), floor of the Q.32 product
    center = 22'(K068_Q16) - 22'(cprod_q >>> 32);
    d_ext  = NUM_W'($signed({1'b0, root}) - center);
    kmul   = NUM_W'(Y_NUM_K);
    kofs   = NUM_W'(Y_OFS);
    mag    = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
    x17    = YQ_W'(mag >> 16);
    rprod  = 34'(x17) * 34'(Y_RECIP);
    xge    = xrem_q >= dsh_q;
    // truncation toward zero: a small negative numerator still lands in row 0
    bin_ok = (den_q > 0) && (32'(ix_q) < X_BINS) && !(yneg_q && qy_q != '0) &&
             (32'(qy_q) < Y_BINS);
    newc      = (mrd == '1) ? mrd : mrd + 1'b1;
    total_inc = (total_q == '1) ? total_q : total_q + 1'b1;
    drop_word = '{accepted: 1'b0, bin_x: '0, bin_y: '0, bin_count: '0,
                  total_count: total_q};
  end

  // log operand order: sample mass, then min bound, then max bound
  always_comb begin
    log_start = 1'b0;
    log_x     = m_q[MASS_W-1:0];
    sq_start  = 1'b0;
    unique case (state_q)
      S_CHK: begin
        log_start = mass_ok;
        sq_start  = mass_ok;
      end
      S_LM: begin
        log_start = log_done;
        log_x     = min_q;
      end
      S_LMIN: begin
        log_start = log_done;
        log_x     = max_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    total_d     = total_q;
    in_d        = in_q;
    res_d       = res_q;
    out_d       = out_q;
    phi_d       = phi_q;
    plo_d       = plo_q;
    m_d         = m_q;
    lm_d        = lm_q;
    lmin_d      = lmin_q;
    lmax_d      = lmax_q;
    den_d       = den_q;
    xrem_d      = xrem_q;
    dsh_d       = dsh_q;
    ix_d        = ix_q;
    xcnt_d      = xcnt_q;
    cprod_d     = cprod_q;
    num_d       = num_q;
    yneg_d      = yneg_q;
    qy_d        = qy_q;
    addr_d      = addr_q;
    mreq        = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          in_d = in_word_i;
          if (in_word_i.op == OP_READ) begin
            res_d = '{accepted: 1'b0, bin_x: in_word_i.read_x,
                      bin_y: in_word_i.read_y, bin_count: '0,
                      total_count: total_q};
            if (rd_in_range) begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = ADDR_W'(in_word_i.read_x) +
                             ADDR_W'(ADDR_W'(in_word_i.read_y) * ADDR_W'(X_BINS));
              state_d      = S_RDATA;
            end else begin
              state_d = S_OUT;
            end
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_RDATA: begin
        res_d.bin_count = mrd;
        state_d         = S_OUT;
      end
      S_MUL: begin
        // mass * Q1.16 factor in two partial products
        phi_d   = 51'(in_q.halo_mass[MASS_W-1:16]) * 51'(hub_q);
        plo_d   = 33'(in_q.halo_mass[15:0]) * 33'(hub_q);
        state_d = S_MSUM;
      end
      S_MSUM: begin
        m_d     = phi_q + 51'(plo_q[32:16]);
        state_d = S_CHK;
      end
      S_CHK: begin
        if (mass_ok) begin
          state_d = S_LM;
        end else begin
          res_d   = drop_word;
          state_d = S_OUT;
        end
      end
      S_LM: begin
        if (log_done) begin
          lm_d    = log_res;
          state_d = S_LMIN;
        end
      end
      S_LMIN: begin
        if (log_done) begin
          lmin_d  = log_res;
          state_d = S_LMAX;
        end
      end
      S_LMAX: begin
        if (log_done) begin
          lmax_d  = log_res;
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        den_d   = den_c;
        xrem_d  = DIV_W'(lm_q - lmin_q) * DIV_W'(X_BINS);
        dsh_d   = DIV_W'(den_c) << (XQ_W - 1);
        ix_d    = '0;
        xcnt_d  = XCNT_W'(XQ_W - 1);
        cprod_d = CPROD_W'(ldiff) * $signed(CPROD_W'(K007_Q32));
        state_d = S_YNUM;
      end
      S_YNUM: begin
        num_d   = d_ext * kmul + kofs;
        state_d = S_YDIV;
      end
      S_YDIV: begin
        yneg_d  = num_q[NUM_W-1];
        qy_d    = YQ_W'(rprod >> 17);
        state_d = S_XDIV;
      end
      S_XDIV: begin
        // restoring division, one quotient bit per cycle
        if (xge) xrem_d = xrem_q - dsh_q;
        ix_d   = {ix_q[XQ_W-2:0], xge};
        dsh_d  = dsh_q >> 1;
        xcnt_d = xcnt_q - 1'b1;
        if (xcnt_q == '0) state_d = S_FIN;
      end
      S_FIN: begin
        if (bin_ok) begin
          addr_d       = ADDR_W'(ix_q) + ADDR_W'(ADDR_W'(qy_q) * ADDR_W'(X_BINS));
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = addr_d;
          state_d      = S_MRD;
        end else begin
          res_d   = drop_word;
          state_d = S_OUT;
        end
      end
      S_MRD: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = addr_q;
        mreq.wr_data = newc;
        total_d      = total_inc;
        res_d = '{accepted: 1'b1, bin_x: BIN_W'(ix_q), bin_y: BIN_W'(qy_q),
                  bin_count: newc, total_count: total_inc};
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      min_q       <= '0;
      max_q       <= '1;
      hub_q       <= HUBBLE_W'(65536);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIN_MASS: min_q <= cfg_data_i;
          CFG_MAX_MASS: max_q <= cfg_data_i;
          CFG_HUBBLE:   hub_q <= cfg_data_i[HUBBLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    res_q   <= res_d;
    out_q   <= out_d;
    phi_q   <= phi_d;
    plo_q   <= plo_d;
    m_q     <= m_d;
    lm_q    <= lm_d;
    lmin_q  <= lmin_d;
    lmax_q  <= lmax_d;
    den_q   <= den_d;
    xrem_q  <= xrem_d;
    dsh_q   <= dsh_d;
    ix_q    <= ix_d;
    xcnt_q  <= xcnt_d;
    cprod_q <= cprod_d;
    num_q   <= num_d;
    yneg_q  <= yneg_d;
    qy_q    <= qy_d;
    addr_q  <= addr_d;
  end

  hsmh_log10 u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .log_o   (log_res)
  );

  // sqrt finishes well inside the first log pass; its result is held
  hsmh_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .q_i     (in_q.ratio_q),
    .s_i     (in_q.ratio_s),
    .done_o  (sq_done),
    .root_o  (root)
  );

  hsmh_hist_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mreq),
    .rd_data_o  (mrd),
    .clr_done_o (clr_done)
  );

  // sqrt always done by the time the bin math reads it
  assign in_ready_o  = (state_q == S_IDLE) && clr_done && (sq_done || !sq_start);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[src/hsmh_checker.sv]
// Port-level checker for the halo shape/mass histogram, bound to the top.
// Depends on hsmh_pkg and halo_shape_mass_histogram_defines.svh.
`timescale 1ns / 1ps
`include "halo_shape_mass_histogram_defines.svh"
module hsmh_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input hsmh_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input hsmh_pkg::out_word_t out_word_o
);
  import hsmh_pkg::*;

  // stalled result holds
  `HSMH_ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o), "output word changed while stalled")

  // a counted sample leaves a nonzero bin count
  `HSMH_ASSERT_CLK(a_bin_nonzero, out_valid_o && out_word_o.accepted |-> out_word_o.bin_count != '0, "counted sample with zero bin count")

  // a counted sample leaves a nonzero total
  `HSMH_ASSERT_CLK(a_total_nonzero, out_valid_o && out_word_o.accepted |-> out_word_o.total_count != '0, "counted sample with zero total")

  // nothing moves during reset
  `HSMH_ASSERT_RST(a_reset_quiet, !rst_ni |-> !out_valid_o && !in_ready_o, "handshake active in reset")

endmodule

bind halo_shape_mass_histogram hsmh_checker u_hsmh_checker (.*);

[test/hsmh_bin_monitor.sv]
// Watches the halo histogram channels and config port, predicts each result
// word and compares it field by field. Depends on hsmh_pkg only.
`timescale 1ns / 1ps
module hsmh_bin_monitor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  hsmh_pkg::in_word_t          in_word_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  hsmh_pkg::out_word_t         out_word_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [hsmh_pkg::MASS_W-1:0] cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import hsmh_pkg::*;

  logic [COUNT_W-1:0] bin_counts [int];
  logic [TOTAL_W-1:0] samples_total;
  logic [MASS_W-1:0]  lo_bound, hi_bound;
  logic [HUBBLE_W-1:0] mass_scale;
  out_word_t          expected_words [$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_words.size();

  // log10 in Q.16 via mantissa squaring
  function automatic longint log10_fix(longint unsigned v);
    longint unsigned e, y, l2;
    if (v == 0) return 0;
    e = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    y  = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
    l2 = e << 16;
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        l2 = l2 | (64'd1 << i);
        y  = y >> 1;
      end
    end
    return longint'((l2 * 64'(LOG10_2_Q32)) >> 32);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic out_word_t predict_bin(in_word_t w);
    out_word_t       o;
    longint unsigned m;
    longint          lm, lmin, lmax, den, ix, aa, center, d, num, iy, h;
    int              idx;
    o = '0;
    o.total_count = samples_total;
    if (op_e'(w.op) == OP_READ) begin
      o.bin_x = w.read_x;
      o.bin_y = w.read_y;
      idx = int'(w.read_x) + X_BINS * int'(w.read_y);
      if (w.read_x < X_BINS && w.read_y < Y_BINS && bin_counts.exists(idx))
        o.bin_count = bin_counts[idx];
      return o;
    end
    m = (64'(w.halo_mass) >> 16) * 64'(mass_scale)
      + (((64'(w.halo_mass) & 64'hFFFF) * 64'(mass_scale)) >> 16);
    if (!(m >= 64'(lo_bound) && m < 64'(hi_bound))) return o;
    if (m < 64'(MASS_FLOOR)) return o;
    lm   = log10_fix(m);
    lmin = log10_fix(64'(lo_bound));
    lmax = log10_fix(64'(hi_bound));
    den  = lmax - lmin;
    if (den <= 0) return o;
    ix = (lm - lmin) * X_BINS / den;
    if (ix < 0 || ix >= X_BINS) return o;
    h      = Y_BINS / 2;
    aa     = longint'(root_floor(64'(w.ratio_q) * 64'(w.ratio_s)));
    center = K068_Q16 - ((lm - 12 * 65536) * longint'(K007_Q32) >>> 32);
    d      = aa - center;
    num    = d * h * 10 + h * 3 * 65536;
    iy     = num / (3 * 65536);       // truncates toward zero
    if (iy < 0 || iy >= Y_BINS) return o;
    idx = int'(ix) + X_BINS * int'(iy);
    if (!bin_counts.exists(idx)) bin_counts[idx] = '0;
    if (bin_counts[idx] != '1) bin_counts[idx] = bin_counts[idx] + 1;
    if (samples_total != '1) samples_total = samples_total + 1;
    o.accepted    = 1'b1;
    o.bin_x       = BIN_W'(ix);
    o.bin_y       = BIN_W'(iy);
    o.bin_count   = bin_counts[idx];
    o.total_count = samples_total;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      bin_counts.delete();
      expected_words.delete();
      samples_total = '0;
      lo_bound      = '0;
      hi_bound      = '1;
      mass_scale    = HUBBLE_W'(65536);
      fails         = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_MASS: lo_bound   = cfg_data_i;
          CFG_MAX_MASS: hi_bound   = cfg_data_i;
          CFG_HUBBLE:   mass_scale = cfg_data_i[HUBBLE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %p", $time, out_word_i);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (out_word_i.accepted !== want.accepted) begin
            $display("%0t: accepted exp %0d got %0d", $time, want.accepted,
                     out_word_i.accepted);
            fails++;
          end
          if (out_word_i.bin_x !== want.bin_x) begin
            $display("%0t: bin_x exp %0d got %0d", $time, want.bin_x, out_word_i.bin_x);
            fails++;
          end
          if (out_word_i.bin_y !== want.bin_y) begin
            $display("%0t: bin_y exp %0d got %0d", $time, want.bin_y, out_word_i.bin_y);
            fails++;
          end
          if (out_word_i.bin_count !== want.bin_count) begin
            $display("%0t: bin_count exp %0d got %0d", $time, want.bin_count,
                     out_word_i.bin_count);
            fails++;
          end
          if (out_word_i.total_count !== want.total_count) begin
            $display("%0t: total_count exp %0d got %0d", $time, want.total_count,
                     out_word_i.total_count);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_words.push_back(predict_bin(in_word_i));
    end
  end

endmodule

[test/testbench.sv]
// Top of the halo histogram testbench: clock, reset, stimulus and verdict.
// Depends on hsmh_pkg, halo_shape_mass_histogram and hsmh_bin_monitor.
`timescale 1ns / 1ps
module testbench;
  import hsmh_pkg::*;

  // index past the register list, must be ignored
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;
  localparam int         STALL_LIMIT   = 60000;
  localparam int         ITEMS_PER_SET = 125;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_ready_o;
  in_word_t           in_word_i;
  logic               out_valid_o, out_ready_i;
  out_word_t          out_word_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [MASS_W-1:0]  cfg_data_i;
  int                 fail_count, pending;

  int send_idle_pct, recv_idle_pct;  // idle odds per cycle, in percent
  int hold_cycles;                   // receiver hold-off request
  int stall_cycles;
  int word_no;

  halo_shape_mass_histogram DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .out_valid_o, .out_ready_i, .out_word_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  hsmh_bin_monitor u_monitor (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_word_i(out_word_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i = 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one word: optional idle cycles, then hold valid until taken
  task automatic send_word(in_word_t w);
    bit taken;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    word_no++;
    forever begin
      #1 taken = in_ready_o;
      @(posedge clk_i);
      if (taken) break;
      @(negedge clk_i);
    end
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    drop_valid();
    wait (pending == 0);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [MASS_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  function automatic in_word_t add_word(logic [MASS_W-1:0] mass, logic [RATIO_W-1:0] q,
                                        logic [RATIO_W-1:0] s);
    in_word_t w;
    w           = '0;
    w.op        = OP_ADD;
    w.halo_mass = mass;
    w.ratio_q   = q;
    w.ratio_s   = s;
    w.read_x    = BIN_W'($urandom);
    w.read_y    = BIN_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t read_word(logic [BIN_W-1:0] x, logic [BIN_W-1:0] y);
    in_word_t w;
    w           = '0;
    w.op        = OP_READ;
    w.halo_mass = MASS_W'({$urandom, $urandom});
    w.ratio_q   = RATIO_W'($urandom);
    w.ratio_s   = RATIO_W'($urandom);
    w.read_x    = x;
    w.read_y    = y;
    return w;
  endfunction

  // mostly plausible halos so that many samples land in a bin
  function automatic in_word_t random_word();
    logic [63:0]        r;
    logic [MASS_W-1:0]  mass;
    logic [RATIO_W-1:0] q, s;
    int                 pick;
    pick = $urandom_range(99);
    if (pick < 25) return read_word(BIN_W'($urandom), BIN_W'($urandom));
    r = {$urandom, $urandom};
    if (pick < 80) begin
      mass = MASS_W'(64'd100000000000 + r % 64'd1000000000000000);
      q    = RATIO_W'($urandom_range(65536, 20000));
      s    = RATIO_W'($urandom_range(int'(q), 5000));
    end else begin
      mass = MASS_W'(r);
      q    = RATIO_W'($urandom_range(65536));
      s    = RATIO_W'($urandom_range(65536));
    end
    return add_word(mass, q, s);
  endfunction

  initial begin
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MIN_MASS;
    cfg_data_i    = '0;
    hold_cycles   = 0;
    word_no       = 0;
    send_idle_pct = 18;
    recv_idle_pct = 79;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: default bounds, log of zero lower bound
    send_word(add_word('0, '0, '0));
    send_word(add_word('1, 17'd65536, 17'd65536));
    send_word(add_word(MASS_FLOOR, 17'd45000, 17'd45000));
    send_word(add_word(MASS_FLOOR - 1, 17'd45000, 17'd45000));
    send_word(add_word(50'd1000000000000, 17'd44000, 17'd44000));
    send_word(add_word(50'd1000000000000, 17'd44000, 17'd44000));
    send_word(add_word(50'd1000000000000, 17'd1000, 17'd1000));    // shape row below zero
    send_word(add_word(50'd1000000000000, 17'd65536, 17'd65536));  // row past the top
    send_word(add_word(50'd1000000000000, 17'd26000, 17'd26000));  // row near zero
    send_word(read_word('0, '0));
    send_word(read_word('1, '1));
    send_word(add_word(50'h2AAAAAAAAAAAA, 17'h15555, 17'h0AAAA));
    drain();

    // bounds, a narrow shrunk scale and an ignored index
    write_reg(CFG_MIN_MASS, 50'd100000000000);
    write_reg(CFG_MAX_MASS, 50'd100000000000000);
    write_reg(CFG_HUBBLE, 50'd45875);
    write_reg(CFG_SPARE_IDX, '1);
    send_word(add_word(50'd142857142857, 17'd40000, 17'd40000));
    send_word(add_word(50'd100000000000000, 17'd40000, 17'd40000));
    send_word(add_word(50'd142857142856000, 17'd40000, 17'd40000));
    drain();

    for (int set = 0; set < 4; set++) begin
      case (set)
        0: begin
          write_reg(CFG_MIN_MASS, '0);
          write_reg(CFG_MAX_MASS, '1);
          write_reg(CFG_HUBBLE, 50'd65536);
        end
        1: begin
          write_reg(CFG_MIN_MASS, 50'd200000000000);
          write_reg(CFG_MAX_MASS, 50'd500000000000000);
          write_reg(CFG_HUBBLE, 50'd131071);
        end
        2: begin  // equal bounds: every add drops
          write_reg(CFG_MIN_MASS, 50'd1000000000000);
          write_reg(CFG_MAX_MASS, 50'd1000000000000);
          write_reg(CFG_HUBBLE, '0);
        end
        default: begin
          write_reg(CFG_MIN_MASS, 50'd1000000000000);
          write_reg(CFG_MAX_MASS, '1);
          write_reg(CFG_HUBBLE, 50'd70000);
        end
      endcase
      for (int k = 0; k < ITEMS_PER_SET; k++) begin
        if (word_no < 180) begin
          send_idle_pct = 18;
          recv_idle_pct = 79;
        end else if (word_no < 360) begin
          send_idle_pct = 79;
          recv_idle_pct = 18;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (set == 1 && k == 10) hold_cycles = 400;  // fill up, input must stall
        if (set == 3 && k == 60) begin
          drop_valid();
          wait (pending == 0);
        end
        send_word(random_word());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
